// File: rtl/klv_pkg.sv
// shared constants and types for the klv stream parser
package klv_pkg;

	// number of leading key bytes compared against the reference keys
	localparam int KEY_MATCH_BYTES = 14;
	localparam int KEY_TABLE_DEPTH = 16;
	localparam int KEY_IDX_W       = $clog2(KEY_TABLE_DEPTH);

	// byte role codes
	localparam logic [2:0] ROLE_OID     = 3'd0;
	localparam logic [2:0] ROLE_KEYLEN  = 3'd1;
	localparam logic [2:0] ROLE_KEY     = 3'd2;
	localparam logic [2:0] ROLE_MARKER  = 3'd3;
	localparam logic [2:0] ROLE_LENBYTE = 3'd4;
	localparam logic [2:0] ROLE_VALUE   = 3'd5;

	// key class codes
	localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
	localparam logic [1:0] CLASS_FRAME   = 2'd1;
	localparam logic [1:0] CLASS_FOOTER  = 2'd2;

	// ber long-form marker bit
	localparam logic [7:0] BER_LONG_MARK = 8'h80;

	// reference keys, zero padded to the table depth
	localparam logic [7:0] FRAME_KEY [KEY_TABLE_DEPTH] = '{
		8'h2B, 8'h34, 8'h01, 8'h02, 8'h01, 8'h05, 8'h0E, 8'h09,
		8'h06, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00
	};
	localparam logic [7:0] FOOTER_KEY [KEY_TABLE_DEPTH] = '{
		8'h2B, 8'h34, 8'h02, 8'h05, 8'h01, 8'h01, 8'h0D, 8'h01,
		8'h02, 8'h01, 8'h01, 8'h11, 8'h01, 8'h00, 8'h00, 8'h00
	};

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_OID     = 6'b000001,
		PH_KEYLEN  = 6'b000010,
		PH_KEY     = 6'b000100,
		PH_MARKER  = 6'b001000,
		PH_LENBYTE = 6'b010000,
		PH_VALUE   = 6'b100000
	} phase_t;

endpackage

// File: rtl/klv_stream_parser.sv
// klv stream parser: byte-wise record parsing with ber length decoding
//
// Takes one byte of a KLV stream per beat and returns one result beat per
// input byte: the byte itself, its role in the record (object id, key
// length, key, length marker, length byte, value), the key class, the
// decoded value length, the record's object id and an end-of-record mark.
// A new byte is accepted every cycle while the result side keeps up; the
// result of a byte appears in the cycle after it is accepted, from the output
// register. While a result waits for out_ready the input is held off, and
// the next byte is taken in the same cycle that the waiting result leaves.
// The parse state lives in a handful of registers updated once per accepted
// byte. Key bytes are matched on the fly against the object frame and footer
// keys over the first 14 bytes; long-form lengths are accumulated
// big-endian modulo 2^32.
module klv_stream_parser
	import klv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [2:0]  byte_role,
	output logic [1:0]  key_class,
	output logic [31:0] value_length,
	output logic [7:0]  object_id,
	output logic        record_end
);

	// parse state
	phase_t      phase_q, phase_n;
	logic [7:0]  oid_q, oid_n;
	logic [7:0]  key_left_q, key_left_n;
	logic [7:0]  key_pos_q, key_pos_n;
	logic [1:0]  match_q, match_n;
	logic [6:0]  len_left_q, len_left_n;
	logic [31:0] len_acc_q, len_acc_n;
	logic [31:0] val_left_q, val_left_n;

	// result register
	logic        out_valid_q;
	logic [7:0]  data_q;
	logic [2:0]  role_q, role_n;
	logic [1:0]  class_q, class_n;
	logic [31:0] vlen_q, vlen_n;
	logic [7:0]  oid_out_q;
	logic        end_q, end_n;

	logic                 accept;
	logic                 in_match_window;
	logic [KEY_IDX_W-1:0] key_idx;
	logic [1:0]           cur_class;
	logic [31:0]          acc_shift;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// key class from the match flags
	assign in_match_window = key_pos_q < 8'(KEY_MATCH_BYTES);
	assign key_idx         = key_pos_q[KEY_IDX_W-1:0];
	always_comb begin
		priority if (in_match_window) begin
			cur_class = CLASS_UNKNOWN;
		end else if (match_q[1]) begin
			cur_class = CLASS_FOOTER;
		end else if (match_q[0]) begin
			cur_class = CLASS_FRAME;
		end else begin
			cur_class = CLASS_UNKNOWN;
		end
	end

	assign acc_shift = {len_acc_q[23:0], in_byte};

	// next state and result for the byte at the input
	always_comb begin
		phase_n    = phase_q;
		oid_n      = oid_q;
		key_left_n = key_left_q;
		key_pos_n  = key_pos_q;
		match_n    = match_q;
		len_left_n = len_left_q;
		len_acc_n  = len_acc_q;
		val_left_n = val_left_q;
		role_n     = ROLE_VALUE;
		class_n    = CLASS_UNKNOWN;
		vlen_n     = '0;
		end_n      = 1'b0;
		unique case (phase_q)
			PH_OID: begin
				role_n  = ROLE_OID;
				oid_n   = in_byte;
				phase_n = PH_KEYLEN;
			end
			PH_KEYLEN: begin
				role_n     = ROLE_KEYLEN;
				key_left_n = in_byte;
				key_pos_n  = '0;
				match_n    = 2'b11;
				phase_n    = (in_byte == 8'd0) ? PH_MARKER : PH_KEY;
			end
			PH_KEY: begin
				role_n = ROLE_KEY;
				if (in_match_window) begin
					if (in_byte != FRAME_KEY[key_idx]) begin
						match_n[0] = 1'b0;
					end
					if (in_byte != FOOTER_KEY[key_idx]) begin
						match_n[1] = 1'b0;
					end
				end
				if (key_pos_q != 8'hFF) begin
					key_pos_n = key_pos_q + 8'd1;
				end
				key_left_n = key_left_q - 8'd1;
				if (key_left_q == 8'd1) begin
					phase_n = PH_MARKER;
				end
			end
			PH_MARKER: begin
				role_n  = ROLE_MARKER;
				class_n = cur_class;
				if ((in_byte & BER_LONG_MARK) == 8'd0) begin
					// short form: length is the byte itself
					len_acc_n  = {24'd0, in_byte};
					val_left_n = {24'd0, in_byte};
					vlen_n     = {24'd0, in_byte};
					if (in_byte == 8'd0) begin
						end_n   = 1'b1;
						phase_n = PH_OID;
					end else begin
						phase_n = PH_VALUE;
					end
				end else begin
					// long form: low seven bits count the length bytes
					len_acc_n  = '0;
					len_left_n = in_byte[6:0];
					if (in_byte[6:0] == 7'd0) begin
						val_left_n = '0;
						end_n      = 1'b1;
						phase_n    = PH_OID;
					end else begin
						phase_n = PH_LENBYTE;
					end
				end
			end
			PH_LENBYTE: begin
				role_n     = ROLE_LENBYTE;
				class_n    = cur_class;
				len_acc_n  = acc_shift;
				len_left_n = len_left_q - 7'd1;
				if (len_left_q == 7'd1) begin
					vlen_n     = acc_shift;
					val_left_n = acc_shift;
					if (acc_shift == 32'd0) begin
						end_n   = 1'b1;
						phase_n = PH_OID;
					end else begin
						phase_n = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				role_n  = ROLE_VALUE;
				class_n = cur_class;
				vlen_n  = len_acc_q;
				if (val_left_q != 32'd0) begin
					val_left_n = val_left_q - 32'd1;
				end
				if (val_left_q <= 32'd1) begin
					end_n   = 1'b1;
					phase_n = PH_OID;
				end
			end
			default: begin
				phase_n = PH_OID;
			end
		endcase
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OID;
			oid_q      <= '0;
			key_left_q <= '0;
			key_pos_q  <= '0;
			match_q    <= 2'b11;
			len_left_q <= '0;
			len_acc_q  <= '0;
			val_left_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			oid_q      <= oid_n;
			key_left_q <= key_left_n;
			key_pos_q  <= key_pos_n;
			match_q    <= match_n;
			len_left_q <= len_left_n;
			len_acc_q  <= len_acc_n;
			val_left_q <= val_left_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q    <= in_byte;
			role_q    <= role_n;
			class_q   <= class_n;
			vlen_q    <= vlen_n;
			oid_out_q <= oid_n;
			end_q     <= end_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = data_q;
	assign byte_role    = role_q;
	assign key_class    = class_q;
	assign value_length = vlen_q;
	assign object_id    = oid_out_q;
	assign record_end   = end_q;

endmodule

// File: rtl/klv_checker.sv
// port-level checks for the klv stream parser, bound to the top level
module klv_checker
	import klv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  in_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  data_byte,
	input logic [2:0]  byte_role,
	input logic [1:0]  key_class,
	input logic [31:0] value_length,
	input logic        record_end
);

	logic       out_beat;
	logic       prev_end_q;
	logic [2:0] prev_role_q;

	assign out_beat = out_valid && out_ready;

	// role and end mark of the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q  <= 1'b1;
			prev_role_q <= ROLE_VALUE;
		end else if (out_beat) begin
			prev_end_q  <= record_end;
			prev_role_q <= byte_role;
		end
	end

	// an accepted byte comes out on the next cycle
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && data_byte == $past(in_byte))
		else $error("accepted byte not echoed");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte)
			&& $stable(byte_role) && $stable(value_length))
		else $error("result changed while stalled");

	// a record starts with its object id right after the previous one ends
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && prev_end_q |-> byte_role == ROLE_OID)
		else $error("record did not start with object id");

	// key length always follows the object id
	a_keylen: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && prev_role_q == ROLE_OID |-> byte_role == ROLE_KEYLEN)
		else $error("key length did not follow object id");

	// no class before the length marker
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (byte_role == ROLE_OID || byte_role == ROLE_KEYLEN
			|| byte_role == ROLE_KEY) |-> key_class == CLASS_UNKNOWN)
		else $error("key class given before length marker");

endmodule

bind klv_stream_parser klv_checker u_klv_checker (.*);
